@@ hw/rtl/lz77_pkg.sv @@
// shared types and constants for the lz77 type 10 decompressor
`timescale 1ns / 1ps

package lz77_pkg;

  // history ring depth (default for the top level parameter)
  localparam int HIST_DEPTH = 4096;

  // fixed by the stream format
  localparam int COUNT_W = 24;   // declared size and produced count
  localparam int DIST_W  = 13;   // 12-bit offset plus one
  localparam int LEN_W   = 5;    // nibble plus minimum match
  localparam int MIN_MATCH = 3;

  localparam logic [7:0] FILL_BYTE   = 8'hFF;
  localparam logic [3:0] FLAG_TOKENS = 4'd8;
  localparam logic [1:0] HDR_LAST    = 2'd3;

  typedef enum logic [1:0] {
    ST_HEADER,
    ST_TOKEN,
    ST_TOKEN2,
    ST_COPY
  } lz_state_t;

endpackage

@@ hw/rtl/lz77_hist.sv @@
// history ring memory with registered read and write-to-read bypass
`timescale 1ns / 1ps

module lz77_hist #(
  parameter int DEPTH = lz77_pkg::HIST_DEPTH,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] q_r;
  logic       byp_r;
  logic [7:0] byp_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    q_r <= mem[rd_addr];
  end

  // same-entry write and read in the same cycle: return the new byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else begin
      byp_r <= wr_en && (wr_addr == rd_addr);
    end
    byp_data_r <= wr_data;
  end

  assign rd_data = byp_r ? byp_data_r : q_r;

endmodule

@@ hw/rtl/lz77_type10_decompressor_core.sv @@
// top level of the lz77 type 10 decompressor: stream parser, copy engine, output register
`timescale 1ns / 1ps

//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------------
//  in      | input     | in_valid / in_ready    | in_byte
//  out     | output    | out_valid / out_ready  | out_byte, out_run_last, out_stream_end
//
//  header, flag and match-first bytes produce no byte and never wait on the output
//  a literal goes out as it is taken; a match copies one byte per cycle while the output
//  is free (3 to 18 bytes), set by the single history read and write port, after its two
//  input bytes; the history read for a copy is issued one byte ahead; a same-entry
//  bypass covers distance one
//  reset is synchronous and clears control state only; history needs no clearing
//  a stalled output register holds the copy engine and any literal in place

module lz77_type10_decompressor_core #(
  parameter int HISTORY_DEPTH = lz77_pkg::HIST_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_stream_end
);

  import lz77_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);

  // control state
  lz_state_t            state_r, state_nxt;
  logic [1:0]           hdr_cnt_r, hdr_cnt_nxt;
  logic [COUNT_W-1:0]   target_r, target_nxt;
  logic [COUNT_W-1:0]   produced_r, produced_nxt;
  logic [7:0]           flag_r, flag_nxt;
  logic [3:0]           tokens_r, tokens_nxt;
  logic [7:0]           token_high_r, token_high_nxt;
  logic [DIST_W-1:0]    dist_r, dist_nxt;
  logic [LEN_W-1:0]     len_r, len_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_byte_r, out_byte_nxt;
  logic                 out_run_last_r, out_run_last_nxt;
  logic                 out_stream_end_r, out_stream_end_nxt;

  // datapath
  logic                 in_fire;
  logic                 out_free;
  logic                 is_match;
  logic                 lit_emit;
  logic                 copy_emit;
  logic                 out_load;
  logic                 emit_done;
  logic                 clear_all;
  logic [COUNT_W-1:0]   prod_inc;
  logic [DIST_W-1:0]    dist_in;
  logic [DIST_W-1:0]    dist_sel;
  logic [COUNT_W-1:0]   rd_src;
  logic [7:0]           hist_rd_data;
  logic [7:0]           copy_byte;
  logic [7:0]           emit_byte;
  logic [COUNT_W-1:0]   target_hdr;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign is_match = flag_r[7];

  always_comb begin
    unique case (state_r)
      ST_HEADER: in_ready = 1'b1;
      ST_TOKEN:  in_ready = (tokens_r == '0) || is_match || out_free;
      ST_TOKEN2: in_ready = 1'b1;
      ST_COPY:   in_ready = 1'b0;
      default:   in_ready = 1'b0;
    endcase
  end

  assign lit_emit  = in_fire && (state_r == ST_TOKEN) && (tokens_r != '0) && !is_match;
  assign copy_emit = (state_r == ST_COPY) && out_free;
  assign out_load  = lit_emit || copy_emit;

  assign prod_inc  = produced_r + COUNT_W'(1);
  assign emit_done = (prod_inc >= target_r);

  // source before the start of the stream reads as fill
  assign copy_byte = (COUNT_W'(dist_r) > produced_r) ? FILL_BYTE : hist_rd_data;
  assign emit_byte = copy_emit ? copy_byte : in_byte;

  // read address targets the next byte to be emitted
  assign dist_in  = {1'b0, token_high_r[3:0], in_byte} + DIST_W'(1);
  assign dist_sel = (state_r == ST_COPY) ? dist_r : dist_in;
  assign rd_src   = produced_r + COUNT_W'(copy_emit) - COUNT_W'(dist_sel);

  lz77_hist #(
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (out_load),
    .wr_addr (produced_r[AW-1:0]),
    .wr_data (emit_byte),
    .rd_addr (rd_src[AW-1:0]),
    .rd_data (hist_rd_data)
  );

  // header bytes 1..3 fill the size little-endian
  always_comb begin
    target_hdr = target_r;
    case (hdr_cnt_r)
      2'd1:    target_hdr = target_r | {16'h0, in_byte};
      2'd2:    target_hdr = target_r | {8'h0, in_byte, 8'h0};
      2'd3:    target_hdr = target_r | {in_byte, 16'h0};
      default: target_hdr = target_r;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    target_nxt     = target_r;
    produced_nxt   = produced_r;
    flag_nxt       = flag_r;
    tokens_nxt     = tokens_r;
    token_high_nxt = token_high_r;
    dist_nxt       = dist_r;
    len_nxt        = len_r;
    clear_all      = 1'b0;

    unique case (state_r)
      ST_HEADER: begin
        if (in_fire) begin
          target_nxt  = target_hdr;
          hdr_cnt_nxt = hdr_cnt_r + 2'd1;
          if (hdr_cnt_r == HDR_LAST) begin
            state_nxt    = ST_TOKEN;
            tokens_nxt   = '0;
            produced_nxt = '0;
            // zero size ends the stream right here
            if (target_hdr == '0) begin
              clear_all = 1'b1;
            end
          end
        end
      end
      ST_TOKEN: begin
        if (in_fire) begin
          if (tokens_r == '0) begin
            flag_nxt   = in_byte;
            tokens_nxt = FLAG_TOKENS;
          end else begin
            flag_nxt   = {flag_r[6:0], 1'b0};
            tokens_nxt = tokens_r - 4'd1;
            if (is_match) begin
              token_high_nxt = in_byte;
              state_nxt      = ST_TOKEN2;
            end else begin
              produced_nxt = prod_inc;
              if (emit_done) begin
                clear_all = 1'b1;
              end
            end
          end
        end
      end
      ST_TOKEN2: begin
        if (in_fire) begin
          dist_nxt  = dist_in;
          len_nxt   = {1'b0, token_high_r[7:4]} + LEN_W'(MIN_MATCH);
          state_nxt = ST_COPY;
        end
      end
      ST_COPY: begin
        if (copy_emit) begin
          produced_nxt = prod_inc;
          len_nxt      = len_r - LEN_W'(1);
          if (emit_done) begin
            // remaining copy bytes past the declared size are dropped
            clear_all = 1'b1;
          end else if (len_r == LEN_W'(1)) begin
            state_nxt = ST_TOKEN;
          end
        end
      end
      default: begin
        clear_all = 1'b1;
      end
    endcase

    if (clear_all) begin
      state_nxt      = ST_HEADER;
      hdr_cnt_nxt    = '0;
      target_nxt     = '0;
      produced_nxt   = '0;
      flag_nxt       = '0;
      tokens_nxt     = '0;
      token_high_nxt = '0;
    end
  end

  // output register parts the engine from the consumer
  always_comb begin
    out_valid_nxt      = out_valid_r;
    out_byte_nxt       = out_byte_r;
    out_run_last_nxt   = out_run_last_r;
    out_stream_end_nxt = out_stream_end_r;
    if (out_load) begin
      out_valid_nxt      = 1'b1;
      out_byte_nxt       = emit_byte;
      out_run_last_nxt   = lit_emit || (len_r == LEN_W'(1)) || emit_done;
      out_stream_end_nxt = emit_done;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_HEADER;
      hdr_cnt_r    <= '0;
      target_r     <= '0;
      produced_r   <= '0;
      flag_r       <= '0;
      tokens_r     <= '0;
      token_high_r <= '0;
      len_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      target_r     <= target_nxt;
      produced_r   <= produced_nxt;
      flag_r       <= flag_nxt;
      tokens_r     <= tokens_nxt;
      token_high_r <= token_high_nxt;
      len_r        <= len_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    dist_r           <= dist_nxt;
    out_byte_r       <= out_byte_nxt;
    out_run_last_r   <= out_run_last_nxt;
    out_stream_end_r <= out_stream_end_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_run_last   = out_run_last_r;
  assign out_stream_end = out_stream_end_r;

  // inside a stream the produced count stays below the declared size
  a_prod_below_target: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_HEADER) |-> (produced_r < target_r))
    else $error("produced count reached declared size inside a stream");

  // a stream end byte always closes its run
  a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stream_end_r) |-> out_run_last_r)
    else $error("stream end without run last");

  // second token byte starts a copy of at least the minimum length
  a_copy_entry: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_TOKEN2) && in_fire) |=>
      ((state_r == ST_COPY) && (len_r >= LEN_W'(MIN_MATCH))))
    else $error("match token did not start a proper copy");

  // a stalled copy stays in place with its produced count unchanged
  a_copy_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_COPY) && !copy_emit) |=> (state_r == ST_COPY) && $stable(produced_r))
    else $error("copy engine moved while output stalled");

endmodule

@@ verif/lz77_stream_checker.sv @@
// watches both channels of the lz77 type 10 decompressor, predicts and checks every output byte
`timescale 1ns / 1ps

module lz77_stream_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       out_run_last,
  input  logic       out_stream_end,
  output int         mismatches,
  output int         pending
);

  import lz77_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       stream_end;
  } out_txn_t;

  // predicted output bytes, oldest first
  out_txn_t decoded_q[$];

  // decoder state
  lz_state_t          dec_state;
  logic [1:0]         hdr_seen;
  logic [COUNT_W-1:0] size_decl;
  logic [COUNT_W-1:0] n_out;
  logic [7:0]         flag_reg;
  logic [3:0]         flag_left;
  logic [7:0]         tok_hi;
  logic [7:0]         hist [HIST_DEPTH];

  initial mismatches = 0;

  function automatic void clear_ctl();
    dec_state = ST_HEADER;
    hdr_seen  = '0;
    size_decl = '0;
    n_out     = '0;
    flag_reg  = '0;
    flag_left = '0;
    tok_hi    = '0;
  endfunction

  // writes one byte to the history and queues it; returns 1 once the declared size is met
  function automatic logic emit_byte(input logic [7:0] c, input logic last_of_item);
    logic done;
    out_txn_t t;
    hist[int'(n_out) % HIST_DEPTH] = c;
    n_out = n_out + COUNT_W'(1);
    done = (n_out >= size_decl);
    t.data       = c;
    t.run_last   = last_of_item | done;
    t.stream_end = done;
    decoded_q.push_back(t);
    return done;
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    logic       done;
    logic       is_match;
    logic [4:0] len;
    logic [12:0] back_dist;
    logic [7:0] c;
    done = 1'b0;
    case (dec_state)
      ST_HEADER: begin
        if (hdr_seen != 2'd0)
          size_decl = size_decl | (COUNT_W'(b) << (8 * (int'(hdr_seen) - 1)));
        if (hdr_seen == HDR_LAST) begin
          hdr_seen  = '0;
          dec_state = ST_TOKEN;
          flag_left = '0;
          n_out     = '0;
          // zero size ends the stream right at the header
          if (size_decl == '0) clear_ctl();
        end else begin
          hdr_seen = hdr_seen + 2'd1;
        end
      end
      ST_TOKEN: begin
        if (flag_left == '0) begin
          flag_reg  = b;
          flag_left = FLAG_TOKENS;
        end else begin
          is_match  = flag_reg[7];
          flag_reg  = flag_reg << 1;
          flag_left = flag_left - 4'd1;
          if (is_match) begin
            tok_hi    = b;
            dec_state = ST_TOKEN2;
          end else begin
            done = emit_byte(b, 1'b1);
          end
        end
      end
      default: begin
        len  = 5'(tok_hi[7:4]) + 5'(MIN_MATCH);
        back_dist = 13'({tok_hi[3:0], b}) + 13'd1;
        dec_state = ST_TOKEN;
        for (int k = 0; k < int'(len) && !done; k++) begin
          // source before stream start reads as fill
          if (COUNT_W'(back_dist) > n_out) c = FILL_BYTE;
          else c = hist[(int'(n_out) - int'(back_dist)) % HIST_DEPTH];
          done = emit_byte(c, k == int'(len) - 1);
        end
      end
    endcase
    if (done) clear_ctl();
  endtask

  task automatic report_mismatch(input string what);
    if (mismatches < 40) $display("[%0t] lz77 check error: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    out_txn_t want;
    if (!rst_n) begin
      clear_ctl();
      decoded_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("unexpected output byte %02h", out_byte));
        end else begin
          want = decoded_q.pop_front();
          if (out_byte !== want.data)
            report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want.data));
          if (out_run_last !== want.run_last)
            report_mismatch($sformatf("out_run_last %0b, want %0b",
                                      out_run_last, want.run_last));
          if (out_stream_end !== want.stream_end)
            report_mismatch($sformatf("out_stream_end %0b, want %0b",
                                      out_stream_end, want.stream_end));
        end
      end
      if (in_valid && in_ready) decode_byte(in_byte);
    end
    pending <= decoded_q.size();
  end

endmodule

@@ verif/tb_lz77_type10_decompressor_core.sv @@
// testbench top for the lz77 type 10 decompressor: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_lz77_type10_decompressor_core;

  // longest stretch without any transaction before the run is declared hung
  localparam int STALL_LIMIT = 5000;
  // receiver hold-off that backs the block up into its input
  localparam int HOLD_CYCLES = 300;
  // settle time after the last result, well above a full 18 byte copy
  localparam int TAIL_CYCLES = 50;
  // minimum input transactions per flow control setting, sent as whole random streams
  localparam int ITEMS_PER_MODE = 20;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       out_run_last;
  logic       out_stream_end;

  int mismatches;
  int pending;

  int   tx_idle_pct;   // sender gap probability, percent per transaction
  int   rx_idle_pct;   // receiver stall probability, percent per cycle
  logic hold_req;      // asks the hold-off process to start
  logic rx_hold;       // receiver forced off while high
  int   idle_cycles;   // watchdog count
  int   items_sent;

  lz77_type10_decompressor_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_stream_end (out_stream_end)
  );

  lz77_stream_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_stream_end (out_stream_end),
    .mismatches     (mismatches),
    .pending        (pending)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stalls at the current rate, forced off during the hold-off
  always @(posedge clk) begin
    out_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  // long receiver hold-off, counted here so the sender keeps offering bytes meanwhile
  initial begin
    rx_hold = 1'b0;
    wait (hold_req === 1'b1);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // watchdog: any transaction on either channel restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one input transaction, with an optional random gap in front of it
  task automatic send_byte(input logic [7:0] b);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // sender goes quiet until every predicted byte has come out
  task automatic drain_wait();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // well-formed stream with random content: header, then flag groups of literals and
  // matches until the declared size is covered; the last match may run past the size
  task automatic send_stream(input logic [23:0] size);
    logic [7:0]  flags;
    logic [3:0]  nib;
    logic [11:0] off;
    int made;
    int slot;
    send_byte(8'($urandom));   // type byte is not examined
    send_byte(size[7:0]);
    send_byte(size[15:8]);
    send_byte(size[23:16]);
    made = 0;
    slot = 8;
    while (made < int'(size)) begin
      if (slot == 8) begin
        flags = 8'($urandom);
        send_byte(flags);
        slot = 0;
      end
      if (flags[7 - slot]) begin
        nib = 4'($urandom);
        // mostly distances into real history, sometimes anything, which can reach
        // before the stream start
        if ($urandom_range(3) == 0) off = 12'($urandom);
        else off = 12'($urandom_range((made < 4095) ? made : 4095, 0));
        send_byte({nib, off[11:8]});
        send_byte(off[7:0]);
        made += int'(nib) + 3;
      end else begin
        send_byte(8'($urandom));
        made++;
      end
      slot++;
    end
  endtask

  // broken stream: a huge declared size followed by raw noise, left unfinished
  task automatic send_truncated();
    send_byte(8'($urandom));
    send_byte(8'($urandom));
    send_byte(8'($urandom));
    send_byte(8'($urandom_range(255, 1)));
    repeat (20) send_byte(8'($urandom));
  endtask

  function automatic logic [23:0] pick_size();
    if ($urandom_range(15) == 0) return 24'd0;
    if ($urandom_range(7) == 0) return 24'($urandom_range(300, 100));
    return 24'($urandom_range(40, 1));
  endfunction

  logic [7:0] dir_bytes [22];

  initial begin
    int mode_start;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_byte     = 8'h00;
    out_ready   = 1'b0;
    hold_req    = 1'b0;
    tx_idle_pct = 27;
    rx_idle_pct = 82;
    idle_cycles = 0;
    items_sent  = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed streams
    // size 5: literal 00, match len 3 dist 2 (first byte before stream start, then
    // overlapping), literal ff
    // size 0: ends at the header, no output
    // size 32: match len 18 dist 4096 all before start, then len 18 dist 1 cut at the size
    dir_bytes = '{8'h10, 8'h05, 8'h00, 8'h00, 8'h40, 8'h00, 8'h00, 8'h01, 8'hFF,
                  8'h10, 8'h00, 8'h00, 8'h00,
                  8'h10, 8'h20, 8'h00, 8'h00, 8'hC0, 8'hFF, 8'hFF, 8'hF0, 8'h00};
    foreach (dir_bytes[i]) send_byte(dir_bytes[i]);
    drain_wait();

    // random streams under three flow control settings
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          tx_idle_pct = 27;
          rx_idle_pct <= 82;
        end
        1: begin
          tx_idle_pct = 82;
          rx_idle_pct <= 27;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct <= 0;
          hold_req <= 1'b1;
        end
      endcase
      mode_start = items_sent;
      while (items_sent - mode_start < ITEMS_PER_MODE) send_stream(pick_size());
      if (mode == 2) send_truncated();
      drain_wait();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
